@@ hdl/hcr_pkg.sv @@
// Package for the hex cube rounding block: fixed-point widths, constants,
// the structs passed between pipeline stages and the saturation function.
// No dependencies.
package hcr_pkg;

   // Fraction bits of the plane coordinates.
   localparam int FRAC_BITS = 16;

   // Pitch register: unsigned Q8.16.
   localparam int PITCH_W = 24;
   localparam int PITCH_FRAC = 16;
   localparam logic [PITCH_W-1:0] PITCH_RESET = 24'd65536;

   // Coordinate and result widths.
   localparam int POINT_W = 32;
   localparam int HEX_W = 16;

   // cos30 in Q0.16 as a positive signed operand, and its fraction shift.
   localparam logic signed [16:0] COS30_OP = 17'sd56756;
   localparam int COS_SHIFT = 15;

   // Datapath widths.
   localparam int PROD_W = POINT_W + PITCH_W + 1;    // point times pitch
   localparam int SX_W = PROD_W - PITCH_FRAC;        // scaled point
   localparam int CPROD_W = SX_W + 17;               // scaled x times cos30
   localparam int C_W = CPROD_W - COS_SHIFT;         // cos30 * x, one extra fraction bit
   localparam int AXIS_W = C_W + 1;                  // axis value with margin
   localparam int R_W = AXIS_W - FRAC_BITS - 1;      // rounded axis
   localparam int RS_W = R_W + 1;                    // rebuilt axis
   localparam int E_W = FRAC_BITS + 1;               // rounding error magnitude

   localparam logic signed [AXIS_W-1:0] AXIS_HALF = AXIS_W'(64'd1 << FRAC_BITS);
   localparam logic [E_W-1:0] E_HALF = E_W'(64'd1 << FRAC_BITS);

   // Axis order within the rounding arrays.
   localparam int AXIS_U = 0;
   localparam int AXIS_V = 1;
   localparam int AXIS_F = 2;

   // Output of the scaling stages.
   typedef struct packed {
      logic                     valid;
      logic signed [C_W-1:0]    c;
      logic signed [SX_W-1:0]   sz;
   } scale_type;

   // Output of the rounding stage.
   typedef struct packed {
      logic                             valid;
      logic signed [2:0][R_W-1:0]       r;
      logic [2:0][E_W-1:0]              e;
   } round_type;

   // Clamp a rebuilt axis to the signed 16-bit range.
   function automatic logic signed [HEX_W-1:0] sat_hex(input logic signed [RS_W-1:0] v);
      logic signed [RS_W-1:0] hi;
      logic signed [RS_W-1:0] lo;
      hi = RS_W'(32767);
      lo = -RS_W'(32768);
      if (v > hi) begin
         return 16'sh7fff;
      end else if (v < lo) begin
         return 16'sh8000;
      end
      return v[HEX_W-1:0];
   endfunction

endpackage

@@ hdl/hcr_scale.sv @@
// Scaling stages of the hex cube rounding pipeline: point times pitch,
// then scaled x times cos30. Two register stages. Depends on hcr_pkg.
module hcr_scale (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic signed [hcr_pkg::POINT_W-1:0]     point_x,
   input  logic signed [hcr_pkg::POINT_W-1:0]     point_z,
   input  logic [hcr_pkg::PITCH_W-1:0]            pitch,
   output hcr_pkg::scale_type                     scale_out
);
   import hcr_pkg::*;

   logic                       valid1_ff;
   logic signed [PROD_W-1:0]   prod_x_ff, prod_x_in;
   logic signed [PROD_W-1:0]   prod_z_ff, prod_z_in;
   logic signed [PITCH_W:0]    pitch_op;

   logic                       valid2_ff;
   logic signed [SX_W-1:0]     sx;
   logic signed [SX_W-1:0]     sz;
   logic signed [CPROD_W-1:0]  c_prod;
   logic signed [C_W-1:0]      c_ff, c_in;
   logic signed [SX_W-1:0]     sz_ff;

   // Stage 1: scale both coordinates by the pitch reciprocal.
   always_comb begin
      pitch_op = $signed({1'b0, pitch});
      prod_x_in = point_x * pitch_op;
      prod_z_in = point_z * pitch_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
      prod_x_ff <= prod_x_in;
      prod_z_ff <= prod_z_in;
   end

   // Stage 2: drop the pitch fraction (floor) and multiply x by cos30.
   always_comb begin
      sx = prod_x_ff[PROD_W-1:PITCH_FRAC];
      sz = prod_z_ff[PROD_W-1:PITCH_FRAC];
      c_prod = sx * COS30_OP;
      c_in = c_prod[CPROD_W-1:COS_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
      c_ff <= c_in;
      sz_ff <= sz;
   end

   assign scale_out.valid = valid2_ff;
   assign scale_out.c = c_ff;
   assign scale_out.sz = sz_ff;

endmodule

@@ hdl/hcr_round.sv @@
// Rounding stage: forms the three cube axes and rounds each half up,
// keeping the rounding error magnitude. Depends on hcr_pkg.
module hcr_round (
   input  logic                 clock,
   input  logic                 reset,
   input  hcr_pkg::scale_type   scale_in,
   output hcr_pkg::round_type   round_out
);
   import hcr_pkg::*;

   logic signed [2:0][AXIS_W-1:0]  axis;
   logic signed [2:0][AXIS_W-1:0]  biased;
   logic [2:0][E_W-1:0]            mod;
   logic signed [AXIS_W-1:0]       c_ext;
   logic signed [AXIS_W-1:0]       sz_ext;
   round_type                      round_ff, round_in;

   // Axes carry one extra fraction bit so that z/2 stays exact.
   always_comb begin
      c_ext = AXIS_W'(scale_in.c);
      sz_ext = AXIS_W'(scale_in.sz);
      axis[AXIS_U] = c_ext - sz_ext;
      axis[AXIS_V] = sz_ext <<< 1;
      axis[AXIS_F] = -sz_ext - c_ext;
   end

   // Round half up; the error is the distance of the remainder from one half.
   always_comb begin
      round_in.valid = scale_in.valid;
      for (int i = 0; i < 3; i++) begin
         biased[i] = axis[i] + AXIS_HALF;
         round_in.r[i] = biased[i][AXIS_W-1:FRAC_BITS+1];
         mod[i] = biased[i][FRAC_BITS:0];
         if (mod[i][FRAC_BITS]) begin
            round_in.e[i] = {1'b0, mod[i][FRAC_BITS-1:0]};
         end else begin
            round_in.e[i] = E_HALF - mod[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff.valid <= 1'b0;
      end else begin
         round_ff.valid <= round_in.valid;
      end
      round_ff.r <= round_in.r;
      round_ff.e <= round_in.e;
   end

   assign round_out = round_ff;

endmodule

@@ hdl/hcr_select.sv @@
// Final stage: rebuilds the axis with the largest rounding error from the
// other two, saturates and registers the result. Depends on hcr_pkg.
module hcr_select (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hcr_pkg::round_type                   round_in,
   output logic                                 out_valid,
   output logic signed [hcr_pkg::HEX_W-1:0]     hex_u,
   output logic signed [hcr_pkg::HEX_W-1:0]     hex_v,
   output logic signed [hcr_pkg::HEX_W-1:0]     hex_f
);
   import hcr_pkg::*;

   logic signed [RS_W-1:0]   ru, rv, rf;
   logic [E_W-1:0]           eu, ev, ef;
   logic                     valid_ff;
   logic signed [HEX_W-1:0]  u_ff, u_in;
   logic signed [HEX_W-1:0]  v_ff, v_in;
   logic signed [HEX_W-1:0]  f_ff, f_in;

   // Rebuild one axis so the three sum to zero; top-error ties rebuild f.
   // Elements of the packed axis array read as unsigned, so they are
   // reinterpreted as signed before they are widened.
   always_comb begin
      ru = RS_W'($signed(round_in.r[AXIS_U]));
      rv = RS_W'($signed(round_in.r[AXIS_V]));
      rf = RS_W'($signed(round_in.r[AXIS_F]));
      eu = round_in.e[AXIS_U];
      ev = round_in.e[AXIS_V];
      ef = round_in.e[AXIS_F];
      if (eu > ev && eu > ef) begin
         ru = -rv - rf;
      end else if (ev > eu && ev > ef) begin
         rv = -ru - rf;
      end else begin
         rf = -ru - rv;
      end
      u_in = sat_hex(ru);
      v_in = sat_hex(rv);
      f_in = sat_hex(rf);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= round_in.valid;
      end
      u_ff <= u_in;
      v_ff <= v_in;
      f_ff <= f_in;
   end

   assign out_valid = valid_ff;
   assign hex_u = u_ff;
   assign hex_v = v_ff;
   assign hex_f = f_ff;

endmodule

@@ hdl/point_to_hex_cube_rounding.sv @@
// Top level of the plane point to hex cube coordinate converter.
// Depends on hcr_pkg, hcr_scale, hcr_round and hcr_select.
//
// Usage:
//   A request is a point (req_point_x, req_point_z) in signed Q16.16. It is
//   taken at a rising edge where start is high and busy is low. busy is
//   always low, so a new request may be issued in every cycle.
//   Each request gives one result (rsp_hex_u, rsp_hex_v, rsp_hex_f), shown
//   for exactly one cycle with rsp_valid high. Results leave in request order.
//   Each request passes through four register stages: pitch multiply, cos30
//   multiply, axis rounding, axis rebuild with saturation.
//   Throughput: one request per cycle, set by the fully pipelined
//   multipliers; no stage is shared between requests.
//   The receiver cannot stall; it must take each result in its cycle.
//   The pitch reciprocal (unsigned Q8.16) is written through csr_we and
//   csr_wdata. The user must write it only while no request is in flight;
//   the block does not enforce it. Requests taken after the write edge use it.
//   Reset (synchronous, active high) empties the pipeline and sets the pitch
//   reciprocal to 1.0.
module point_to_hex_cube_rounding (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [hcr_pkg::POINT_W-1:0]   req_point_x,
   input  logic signed [hcr_pkg::POINT_W-1:0]   req_point_z,
   output logic                                 rsp_valid,
   output logic signed [hcr_pkg::HEX_W-1:0]     rsp_hex_u,
   output logic signed [hcr_pkg::HEX_W-1:0]     rsp_hex_v,
   output logic signed [hcr_pkg::HEX_W-1:0]     rsp_hex_f,
   input  logic                                 csr_we,
   input  logic [hcr_pkg::PITCH_W-1:0]          csr_wdata
);
   import hcr_pkg::*;

   logic [PITCH_W-1:0]  pitch_ff, pitch_in;
   logic                req_take;
   scale_type           scale_bus;
   round_type           round_bus;

   // The pipeline advances every cycle, so requests are never refused.
   assign busy = 1'b0;
   assign req_take = start && !busy;

   // Pitch reciprocal register.
   always_comb begin
      pitch_in = pitch_ff;
      if (csr_we) begin
         pitch_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= PITCH_RESET;
      end else begin
         pitch_ff <= pitch_in;
      end
   end

   hcr_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .point_x   (req_point_x),
      .point_z   (req_point_z),
      .pitch     (pitch_ff),
      .scale_out (scale_bus)
   );

   hcr_round u_round (
      .clock     (clock),
      .reset     (reset),
      .scale_in  (scale_bus),
      .round_out (round_bus)
   );

   hcr_select u_select (
      .clock     (clock),
      .reset     (reset),
      .round_in  (round_bus),
      .out_valid (rsp_valid),
      .hex_u     (rsp_hex_u),
      .hex_v     (rsp_hex_v),
      .hex_f     (rsp_hex_f)
   );

   // Every taken request yields a valid result from the pipeline.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |-> ##4 rsp_valid)
      else $error("request did not produce a result after four cycles");

   // A result never appears without a matching earlier request.
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_take, 4))
      else $error("result without a matching request");

   // Unclamped results lie on the cube plane u + v + f = 0.
   a_cube_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hex_u != 16'sh7fff && rsp_hex_u != 16'sh8000
         && rsp_hex_v != 16'sh7fff && rsp_hex_v != 16'sh8000
         && rsp_hex_f != 16'sh7fff && rsp_hex_f != 16'sh8000)
      |-> (18'(rsp_hex_u) + 18'(rsp_hex_v) + 18'(rsp_hex_f) == 18'sd0))
      else $error("cube coordinates do not sum to zero");

endmodule

@@ sim/point_to_hex_cube_rounding_tb.sv @@
// Self-checking testbench for point_to_hex_cube_rounding: drives plane points and pitch
// register writes, predicts each hex cell in cube coordinates and checks every result.
// Depends on hcr_pkg and the point_to_hex_cube_rounding RTL.
module point_to_hex_cube_rounding_tb;
   import hcr_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 8;
   // This leaves margin over the pipeline from request to result.
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PER_PHASE = 60;
   localparam int MAX_REPORTS = 10;
   localparam int TIMEOUT_CYCLES = 50000;
   localparam longint COS30_Q16 = 56756;

   typedef enum logic [1:0] {STEP_POINT, STEP_PITCH, STEP_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type               kind;
      logic signed [POINT_W-1:0]   x;
      logic signed [POINT_W-1:0]   z;
      logic [PITCH_W-1:0]          pitch;
      int                          gap;
   } work_step_type;

   typedef struct {
      logic signed [HEX_W-1:0] u;
      logic signed [HEX_W-1:0] v;
      logic signed [HEX_W-1:0] f;
   } hex_cell_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic signed [POINT_W-1:0]   req_point_x = '0;
   logic signed [POINT_W-1:0]   req_point_z = '0;
   logic                        rsp_valid;
   logic signed [HEX_W-1:0]     rsp_hex_u;
   logic signed [HEX_W-1:0]     rsp_hex_v;
   logic signed [HEX_W-1:0]     rsp_hex_f;
   logic                        csr_we = 1'b0;
   logic [PITCH_W-1:0]          csr_wdata = PITCH_RESET;

   work_step_type        work_list[$];
   hex_cell_type         expected_cells[$];
   logic [PITCH_W-1:0]   pitch_model = PITCH_RESET;
   int                   hold_off = 0;
   int                   quiet_cycles = 0;
   int                   mismatches = 0;
   int                   burst_left = 0;
   bit                   burst_mode = 1'b0;

   point_to_hex_cube_rounding u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_point_x (req_point_x),
      .req_point_z (req_point_z),
      .rsp_valid   (rsp_valid),
      .rsp_hex_u   (rsp_hex_u),
      .rsp_hex_v   (rsp_hex_v),
      .rsp_hex_f   (rsp_hex_f),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Clamp a rebuilt coordinate to the signed 16-bit result range.
   function automatic logic signed [HEX_W-1:0] clamp_hex(longint val);
      if (val > 32767) return 16'sh7fff;
      if (val < -32768) return 16'sh8000;
      return val[HEX_W-1:0];
   endfunction

   // Hex cell holding a point, for a given pitch reciprocal.
   function automatic hex_cell_type hex_cell_of(logic signed [POINT_W-1:0] x,
                                                logic signed [POINT_W-1:0] z,
                                                logic [PITCH_W-1:0] pitch);
      longint       scale;
      longint       sx;
      longint       sz;
      longint       c;
      longint       half;
      longint       one;
      longint       axis [3];
      longint       rnd [3];
      longint       err [3];
      hex_cell_type res;
      scale = longint'(pitch);
      sx = (longint'(x) * scale) >>> PITCH_FRAC;
      sz = (longint'(z) * scale) >>> PITCH_FRAC;
      // Axes carry one extra fraction bit so that z/2 stays exact.
      c = (sx * COS30_Q16) >>> COS_SHIFT;
      axis[AXIS_U] = c - sz;
      axis[AXIS_V] = 2 * sz;
      axis[AXIS_F] = -sz - c;
      half = longint'(1) << FRAC_BITS;
      one = half << 1;
      // Round each axis half up and keep the size of its rounding error.
      for (int i = 0; i < 3; i++) begin
         rnd[i] = (axis[i] + half) >>> (FRAC_BITS + 1);
         err[i] = axis[i] - rnd[i] * one;
         if (err[i] < 0) err[i] = -err[i];
      end
      // Rebuild the worst axis; a tie for the worst falls through to f.
      if (err[AXIS_U] > err[AXIS_V] && err[AXIS_U] > err[AXIS_F]) begin
         rnd[AXIS_U] = -rnd[AXIS_V] - rnd[AXIS_F];
      end else if (err[AXIS_V] > err[AXIS_U] && err[AXIS_V] > err[AXIS_F]) begin
         rnd[AXIS_V] = -rnd[AXIS_U] - rnd[AXIS_F];
      end else begin
         rnd[AXIS_F] = -rnd[AXIS_U] - rnd[AXIS_V];
      end
      res.u = clamp_hex(rnd[AXIS_U]);
      res.v = clamp_hex(rnd[AXIS_V]);
      res.f = clamp_hex(rnd[AXIS_F]);
      return res;
   endfunction

   // Idle cycles before a request; runs of back-to-back requests alternate with gaps.
   function automatic int draw_gap();
      if (burst_left == 0) begin
         burst_left = $urandom_range(8, 30);
         burst_mode = ($urandom_range(0, 2) == 0);
      end
      burst_left--;
      return burst_mode ? 0 : $urandom_range(0, 7);
   endfunction

   // Coordinates: full range, a few units around the origin, a quarter-unit
   // grid that lands on exact halves, and values next to the range ends.
   function automatic logic signed [POINT_W-1:0] random_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
         2: return ($urandom_range(0, 63) - 32) * 32'h0000_4000;
         default: begin
            if ($urandom_range(0, 1)) return 32'h7fff_ff00 + $urandom_range(0, 255);
            return 32'h8000_0000 + $urandom_range(0, 255);
         end
      endcase
   endfunction

   task automatic add_point(logic signed [POINT_W-1:0] x, logic signed [POINT_W-1:0] z);
      work_step_type s;
      s.kind = STEP_POINT;
      s.x = x;
      s.z = z;
      s.pitch = '0;
      s.gap = draw_gap();
      work_list.push_back(s);
   endtask

   task automatic add_control(step_kind_type kind, logic [PITCH_W-1:0] pitch);
      work_step_type s;
      s.kind = kind;
      s.x = '0;
      s.z = '0;
      s.pitch = pitch;
      s.gap = 0;
      work_list.push_back(s);
   endtask

   // Request driver: issues points, and writes the pitch only once the pipeline is empty.
   always @(posedge clock) begin : drive_requests
      logic          start_next;
      logic          we_next;
      work_step_type head;
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
         hold_off = 0;
         quiet_cycles = 0;
         pitch_model = PITCH_RESET;
      end else begin
         start_next = start;
         we_next = 1'b0;
         // A request is taken at this edge.
         if (start && !busy) begin
            expected_cells.push_back(hex_cell_of(req_point_x, req_point_z, pitch_model));
            start_next = 1'b0;
         end
         if (start_next || expected_cells.size() != 0) quiet_cycles = 0;
         else quiet_cycles++;
         if (!start_next && hold_off > 0) begin
            hold_off--;
         end else if (!start_next && work_list.size() != 0) begin
            head = work_list[0];
            case (head.kind)
               STEP_POINT: begin
                  req_point_x <= head.x;
                  req_point_z <= head.z;
                  start_next = 1'b1;
                  void'(work_list.pop_front());
                  if (work_list.size() != 0) hold_off = work_list[0].gap;
               end
               STEP_PITCH: begin
                  if (quiet_cycles >= SETTLE_CYCLES) begin
                     csr_wdata <= head.pitch;
                     we_next = 1'b1;
                     pitch_model = head.pitch;
                     void'(work_list.pop_front());
                  end
               end
               STEP_DRAIN: begin
                  if (quiet_cycles >= SETTLE_CYCLES) void'(work_list.pop_front());
               end
               default: ;
            endcase
         end
         start <= start_next;
         csr_we <= we_next;
      end
   end

   // Result monitor: every strobed result must match the oldest predicted cell.
   always @(posedge clock) begin : check_results
      hex_cell_type want;
      if (!reset && rsp_valid) begin
         if (expected_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: got (%0d,%0d,%0d)",
                        rsp_hex_u, rsp_hex_v, rsp_hex_f);
         end else begin
            want = expected_cells.pop_front();
            if (want.u !== rsp_hex_u || want.v !== rsp_hex_v || want.f !== rsp_hex_f) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("hex cell mismatch: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                           want.u, want.v, want.f, rsp_hex_u, rsp_hex_v, rsp_hex_f);
            end
         end
      end
   end

   // Stimulus plan and end of run.
   initial begin : run_test
      logic [PITCH_W-1:0]          phase_pitch [7];
      logic signed [POINT_W-1:0]   corner [3];
      int                          drain_at;
      phase_pitch[0] = 24'hff_ffff;
      phase_pitch[1] = 24'h00_0001;
      phase_pitch[2] = 24'h00_0000;
      phase_pitch[3] = $urandom_range(1, 24'hff_ffff);
      phase_pitch[4] = $urandom_range(24'h00_4000, 24'h04_0000);
      phase_pitch[5] = $urandom_range(24'h00_0100, 24'h00_4000);
      phase_pitch[6] = PITCH_RESET;
      corner[0] = 32'h8000_0000;
      corner[1] = 32'h7fff_ffff;
      corner[2] = 32'h0000_0000;

      // Directed points at the reset pitch of 1.0.
      add_point(32'h0000_0000, 32'h0000_0000);   // all errors equal, f rebuilt
      add_point(32'h0000_0000, 32'h0000_8000);   // v has the largest error
      add_point(32'h0000_9000, 32'hffff_c000);   // u has the largest error
      add_point(32'h0001_0000, 32'h0000_0000);   // u and f tie
      add_point(32'h0000_0000, 32'hffff_8000);
      add_point(32'h0000_0000, 32'h0001_8000);
      add_point(32'hffff_ffff, 32'hffff_ffff);
      add_point(32'h0000_0001, 32'h0000_0001);
      add_point(32'h1234_5678, 32'hedcb_a988);
      add_point(32'h0001_bb68, 32'hfffe_4498);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            add_point(corner[i], corner[j]);

      // Phases at several pitches, the range ends among them.
      for (int p = 0; p < 7; p++) begin
         add_control(STEP_PITCH, phase_pitch[p]);
         add_point(corner[0], corner[1]);
         add_point(corner[1], corner[0]);
         add_point(32'h0000_8000, 32'hffff_8000);
         drain_at = $urandom_range(5, RANDOM_PER_PHASE - 5);
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            if (k == drain_at) add_control(STEP_DRAIN, '0);
            add_point(random_coord(), random_coord());
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (work_list.size() != 0 || start) @(posedge clock);
      for (int n = 0; n < 4 * SETTLE_CYCLES && expected_cells.size() != 0; n++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_cells.size() == 0) begin
         $display("PASS point_to_hex_cube_rounding");
      end else begin
         $display("FAIL point_to_hex_cube_rounding");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("FAIL point_to_hex_cube_rounding");
      $finish;
   end

endmodule
